// ===== design/tte_pkg.sv =====
// Shared types and constants for the timer table expiry block.
// No dependencies; used by timer_table_expiry and by the testbench.
package tte_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int IDX_W      = $clog2(NUM_TIMERS);
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int SLOT_W     = 4;
   localparam int TIME_W     = 32;
   localparam int FCNT_W     = 5;

   typedef enum logic [1:0] {
      OP_SET       = 2'd0,
      OP_PROCESS   = 2'd1,
      OP_TERMINATE = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_SLEEP   = 2'd0,
      KIND_IDLE    = 2'd1,
      KIND_TIMEOUT = 2'd2,
      KIND_OTHER   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_DONE
   } state_type;

endpackage

// ===== design/tte_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module tte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/timer_table_expiry.sv =====
// Timer table expiry: a table of timer slots with an ordered expiry scan.
// Depends on tte_pkg and tte_ram.
//
// Usage:
//  - Command channel: drive req_* and raise start; the beat is taken at a
//    clock edge where start is high and busy is low.
//  - Set (op 0) never raises busy: duration and arming sequence go to one
//    RAM, the issue time (sleep and timeout only) to a second RAM, the armed
//    bit and a per-slot stamp bit to flops. Set returns no result.
//  - Process (op 1) and terminate (op 2) raise busy and run a selection
//    sort over the table: each pass reads every slot once from the RAMs
//    (one read a cycle, registered read data) and picks the next slot in
//    duration / arming-age / index order, then an evaluate state handles it.
//    With n armed slots this takes n + 1 passes and a final done state,
//    each pass reading slot by slot through the single RAM read port.
//  - Results: rsp_strobe marks a result beat for exactly one cycle. The
//    last beat of an operation has rsp_last set; an operation that reports
//    nothing gives one beat with rsp_has_timer low. The receiver cannot
//    stall, so results are driven without backpressure.
//  - One result is held back until the next one is known, so last can be
//    flagged on the correct beat.
//  - Reset (synchronous, active high) disarms all slots, clears the stamp
//    bits and the sequence counter and returns to idle. RAM contents need
//    no clearing: arming writes duration and sequence, and a slot whose
//    issue time was never stamped reads it as zero through its stamp bit.
module timer_table_expiry (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [3:0]            req_slot,
   input  logic [1:0]            req_kind,
   input  logic [31:0]           req_value,
   input  logic [31:0]           req_now,
   output logic                  rsp_strobe,
   output logic                  rsp_has_timer,
   output logic [3:0]            rsp_woken_slot,
   output logic                  rsp_elapsed,
   output logic [4:0]            rsp_fired_count,
   output logic                  rsp_last
);
   import tte_pkg::*;

   state_type state_ff, state_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;
   logic [NUM_TIMERS-1:0] stamp_ff, stamp_in;
   logic [NUM_TIMERS-1:0] cand_ff, cand_in;
   logic [TIME_W-1:0] seq_ff, seq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic term_ff, term_in;
   logic sleep_ff, sleep_in;
   logic [TIME_W-1:0] value_ff, value_in;
   logic best_found_ff, best_found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_dur_ff, best_dur_in;
   logic [TIME_W-1:0] best_age_ff, best_age_in;
   logic [TIME_W-1:0] best_issue_ff, best_issue_in;
   logic [TIME_W-1:0] group_ff, group_in;
   logic grp_valid_ff, grp_valid_in;
   logic blocked_ff, blocked_in;
   logic pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic pend_el_ff, pend_el_in;
   logic [FCNT_W-1:0] count_ff, count_in;
   // result beat registers
   logic strobe_ff, strobe_in;
   logic has_ff, has_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic el_ff, el_in;
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic last_ff, last_in;

   // RAM ports
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [2*TIME_W-1:0]   ds_wdata, ds_rdata;
   logic                  it_wr_en;
   logic [TIME_W-1:0]     it_rdata;
   logic [IDX_W-1:0]      rd_addr;

   logic                  accept;
   logic                  slot_ok;
   logic [IDX_W-1:0]      scan_idx;
   logic [TIME_W-1:0]     rd_dur, rd_seq, rd_age;
   logic                  better;
   logic                  same_grp, blk_eff, fire;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign slot_ok  = int'(req_slot) < NUM_TIMERS;
   assign wr_addr  = IDX_W'(req_slot);
   assign rd_addr  = cnt_ff[IDX_W-1:0];
   assign scan_idx = IDX_W'(cnt_ff - CNT_W'(1));
   assign rd_dur   = ds_rdata[2*TIME_W-1:TIME_W];
   assign rd_seq   = ds_rdata[TIME_W-1:0];
   assign rd_age   = seq_ff - rd_seq;
   assign better   = !best_found_ff || (rd_dur < best_dur_ff) ||
                     ((rd_dur == best_dur_ff) && (rd_age > best_age_ff));
   assign same_grp = grp_valid_ff && (group_ff == best_dur_ff);
   assign blk_eff  = same_grp && blocked_ff;
   assign fire     = term_ff ? 1'b1 :
                     sleep_ff ? ((value_ff - best_issue_ff) >= best_dur_ff) :
                     (value_ff >= best_dur_ff);

   // arming writes: duration and sequence always, issue time on sleep/timeout
   assign wr_en    = accept && (req_op == OP_SET) && slot_ok && (req_value != '0);
   assign it_wr_en = wr_en && ((req_kind == KIND_SLEEP) || (req_kind == KIND_TIMEOUT));
   assign ds_wdata = {req_value, seq_ff + TIME_W'(1)};

   tte_ram #(.WIDTH(2*TIME_W), .DEPTH(NUM_TIMERS)) u_dur_seq (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ds_wdata),
      .rd_addr (rd_addr),
      .rd_data (ds_rdata)
   );

   tte_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_issue (
      .clock   (clock),
      .wr_en   (it_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_now),
      .rd_addr (rd_addr),
      .rd_data (it_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      armed_in      = armed_ff;
      stamp_in      = stamp_ff;
      cand_in       = cand_ff;
      seq_in        = seq_ff;
      cnt_in        = cnt_ff;
      term_in       = term_ff;
      sleep_in      = sleep_ff;
      value_in      = value_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_dur_in   = best_dur_ff;
      best_age_in   = best_age_ff;
      best_issue_in = best_issue_ff;
      group_in      = group_ff;
      grp_valid_in  = grp_valid_ff;
      blocked_in    = blocked_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_el_in    = pend_el_ff;
      count_in      = count_ff;
      strobe_in     = 1'b0;
      has_in        = has_ff;
      slot_in       = slot_ff;
      el_in         = el_ff;
      fcnt_in       = fcnt_ff;
      last_in       = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_SET: begin
                     if (slot_ok) begin
                        if (req_value == '0) begin
                           armed_in[wr_addr] = 1'b0;
                        end else begin
                           armed_in[wr_addr] = 1'b1;
                           seq_in = seq_ff + TIME_W'(1);
                           if (it_wr_en) begin
                              stamp_in[wr_addr] = 1'b1;
                           end
                        end
                     end
                  end
                  OP_PROCESS, OP_TERMINATE: begin
                     state_in      = ST_SCAN;
                     term_in       = (req_op == OP_TERMINATE);
                     sleep_in      = (req_kind == KIND_SLEEP);
                     value_in      = req_value;
                     cand_in       = armed_ff;
                     cnt_in        = '0;
                     best_found_in = 1'b0;
                     grp_valid_in  = 1'b0;
                     blocked_in    = 1'b0;
                     pend_valid_in = 1'b0;
                     count_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read issued at cnt, data compared in the following cycle
            if (cnt_ff != '0) begin
               if (cand_ff[scan_idx] && better) begin
                  best_found_in = 1'b1;
                  best_idx_in   = scan_idx;
                  best_dur_in   = rd_dur;
                  best_age_in   = rd_age;
                  // never-stamped issue time reads as zero
                  best_issue_in = stamp_ff[scan_idx] ? it_rdata : '0;
               end
            end
            if (cnt_ff == CNT_W'(NUM_TIMERS)) begin
               state_in = ST_EVAL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_EVAL: begin
            if (!best_found_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in             = ST_SCAN;
               cnt_in               = '0;
               best_found_in        = 1'b0;
               cand_in[best_idx_ff] = 1'b0;
               group_in             = best_dur_ff;
               grp_valid_in         = 1'b1;
               blocked_in           = blk_eff;
               if (!blk_eff) begin
                  if (fire) begin
                     armed_in[best_idx_ff] = 1'b0;
                     if (pend_valid_ff) begin
                        strobe_in = 1'b1;
                        has_in    = 1'b1;
                        slot_in   = pend_idx_ff;
                        el_in     = pend_el_ff;
                        fcnt_in   = count_ff + FCNT_W'(1);
                        last_in   = 1'b0;
                        count_in  = count_ff + FCNT_W'(1);
                     end
                     pend_valid_in = 1'b1;
                     pend_idx_in   = best_idx_ff;
                     pend_el_in    = !term_ff;
                  end else begin
                     blocked_in = 1'b1;
                  end
               end
            end
         end
         ST_DONE: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            last_in   = 1'b1;
            if (pend_valid_ff) begin
               has_in  = 1'b1;
               slot_in = pend_idx_ff;
               el_in   = pend_el_ff;
               fcnt_in = count_ff + FCNT_W'(1);
            end else begin
               has_in  = 1'b0;
               slot_in = '0;
               el_in   = 1'b0;
               fcnt_in = '0;
            end
            pend_valid_in = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         armed_ff      <= '0;
         stamp_ff      <= '0;
         seq_ff        <= '0;
         strobe_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         armed_ff      <= armed_in;
         stamp_ff      <= stamp_in;
         seq_ff        <= seq_in;
         strobe_ff     <= strobe_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      cnt_ff        <= cnt_in;
      term_ff       <= term_in;
      sleep_ff      <= sleep_in;
      value_ff      <= value_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_dur_ff   <= best_dur_in;
      best_age_ff   <= best_age_in;
      best_issue_ff <= best_issue_in;
      group_ff      <= group_in;
      grp_valid_ff  <= grp_valid_in;
      blocked_ff    <= blocked_in;
      pend_idx_ff   <= pend_idx_in;
      pend_el_ff    <= pend_el_in;
      has_ff        <= has_in;
      slot_ff       <= slot_in;
      el_ff         <= el_in;
      fcnt_ff       <= fcnt_in;
      last_ff       <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_has_timer   = has_ff;
   assign rsp_woken_slot  = SLOT_W'(slot_ff);
   assign rsp_elapsed     = el_ff;
   assign rsp_fired_count = fcnt_ff;
   assign rsp_last        = last_ff;
endmodule

// ===== tb/sv/tte_checker.sv =====
// Scoreboard for the timer table expiry block: mirrors the slot table,
// predicts the result beats of each accepted command and compares them.
// Depends on tte_pkg.
`timescale 1ns / 1ps
module tte_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_slot,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_value,
   input  logic [31:0] req_now,
   input  logic        rsp_strobe,
   input  logic        rsp_has_timer,
   input  logic [3:0]  rsp_woken_slot,
   input  logic        rsp_elapsed,
   input  logic [4:0]  rsp_fired_count,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending,
   output int          wake_beats
);
   import tte_pkg::*;

   typedef struct packed {
      logic       has_timer;
      logic [3:0] woken_slot;
      logic       elapsed;
      logic [4:0] fired_count;
      logic       last;
   } wake_beat_type;

   logic          slot_armed [NUM_TIMERS];
   logic [31:0]   slot_dur   [NUM_TIMERS];
   logic [31:0]   slot_issue [NUM_TIMERS];
   logic [31:0]   slot_seq   [NUM_TIMERS];
   logic [31:0]   seq_ctr;
   wake_beat_type wake_queue [$];

   function automatic bit scans_before(int a, int b);
      logic [31:0] age_a, age_b;
      age_a = seq_ctr - slot_seq[a];
      age_b = seq_ctr - slot_seq[b];
      if (slot_dur[a] != slot_dur[b]) return slot_dur[a] < slot_dur[b];
      if (age_a != age_b) return age_a > age_b;
      return a < b;
   endfunction

   task automatic predict_wakes(op_type op, kind_type kind, logic [31:0] value);
      int            order [$];
      int            s, pos, cnt;
      bit            blocked, fire;
      logic [31:0]   group;
      wake_beat_type wb;
      cnt = 0; blocked = 0; group = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (slot_armed[i]) begin
            pos = order.size();
            while (pos > 0 && scans_before(i, order[pos-1])) pos--;
            order.insert(pos, i);
         end
      end
      foreach (order[k]) begin
         s = order[k];
         if (k == 0 || slot_dur[s] != group) begin
            group = slot_dur[s];
            blocked = 0;
         end
         if (op == OP_TERMINATE) fire = 1;
         else if (blocked) fire = 0;
         else if (kind == KIND_SLEEP) fire = (value - slot_issue[s]) >= slot_dur[s];
         else fire = value >= slot_dur[s];
         if (fire) begin
            slot_armed[s] = 0;
            cnt++;
            wb.has_timer   = 1;
            wb.woken_slot  = s[3:0];
            wb.elapsed     = (op == OP_PROCESS);
            wb.fired_count = cnt[4:0];
            wb.last        = 0;
            wake_queue.push_back(wb);
         end else if (op == OP_PROCESS && !blocked) begin
            blocked = 1;
         end
      end
      if (cnt == 0) wake_queue.push_back('{0, 0, 0, 0, 1});
      else wake_queue[$].last = 1;
   endtask

   assign pending = wake_queue.size();

   always @(posedge clock) begin
      wake_beat_type exp_b;
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            slot_armed[i] = 0;
            slot_dur[i]   = '0;
            slot_issue[i] = '0;
            slot_seq[i]   = '0;
         end
         seq_ctr = '0;
         fail_count = 0;
         wake_beats = 0;
         wake_queue.delete();
      end else begin
         if (rsp_strobe) begin
            wake_beats++;
            if (wake_queue.size() == 0) begin
               $error("unexpected result beat, slot %0d", rsp_woken_slot);
               fail_count++;
            end else begin
               exp_b = wake_queue.pop_front();
               if (rsp_has_timer !== exp_b.has_timer) begin
                  $error("has_timer exp %0d got %0d", exp_b.has_timer, rsp_has_timer);
                  fail_count++;
               end
               if (rsp_woken_slot !== exp_b.woken_slot) begin
                  $error("woken_slot exp %0d got %0d", exp_b.woken_slot, rsp_woken_slot);
                  fail_count++;
               end
               if (rsp_elapsed !== exp_b.elapsed) begin
                  $error("elapsed exp %0d got %0d", exp_b.elapsed, rsp_elapsed);
                  fail_count++;
               end
               if (rsp_fired_count !== exp_b.fired_count) begin
                  $error("fired_count exp %0d got %0d", exp_b.fired_count,
                         rsp_fired_count);
                  fail_count++;
               end
               if (rsp_last !== exp_b.last) begin
                  $error("last exp %0d got %0d", exp_b.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            case (op_type'(req_op))
               OP_SET: begin
                  if (req_value == 0) slot_armed[req_slot] = 0;
                  else begin
                     slot_armed[req_slot] = 1;
                     slot_dur[req_slot] = req_value;
                     if (req_kind == KIND_SLEEP || req_kind == KIND_TIMEOUT)
                        slot_issue[req_slot] = req_now;
                     seq_ctr = seq_ctr + 1;
                     slot_seq[req_slot] = seq_ctr;
                  end
               end
               OP_PROCESS, OP_TERMINATE:
                  predict_wakes(op_type'(req_op), kind_type'(req_kind), req_value);
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the timer table expiry testbench: clock, reset, command stimulus
// and verdict. Depends on tte_pkg, timer_table_expiry and tte_checker.
`timescale 1ns / 1ps
module tb_top;
   import tte_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic [3:0]  req_slot = '0;
   logic [1:0]  req_kind = '0;
   logic [31:0] req_value = '0;
   logic [31:0] req_now = '0;
   logic        rsp_strobe, rsp_has_timer, rsp_elapsed, rsp_last;
   logic [3:0]  rsp_woken_slot;
   logic [4:0]  rsp_fired_count;
   int          fail_count, pending, wake_beats;
   int          n_cmds;
   logic [31:0] clock_now = 0;   // running time base for issue stamps

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   timer_table_expiry uut (.*);
   tte_checker chk (.*);

   // One command beat: drive at the falling edge, hold until taken.
   task automatic send_cmd(op_type op, logic [3:0] slot, kind_type kind,
                           logic [31:0] value, logic [31:0] now_t, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) @(negedge clock) start <= 0;
      @(negedge clock);
      start     <= 1;
      req_op    <= op;
      req_slot  <= slot;
      req_kind  <= kind;
      req_value <= value;
      req_now   <= now_t;
      do @(posedge clock); while (busy);
      n_cmds++;
      @(negedge clock) start <= 0;
   endtask

   // Random duration: mostly a few small values so groups share durations.
   function automatic logic [31:0] rand_dur();
      case ($urandom_range(0, 9))
         0:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         1:       return $urandom;
         2:       return 0;
         default: return $urandom_range(1, 6) * 10;
      endcase
   endfunction

   initial begin
      bit gaps;
      n_cmds = 0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 0;

      // Directed: empty reports, extremes, rearm, wrap, kind three, op 3.
      send_cmd(OP_PROCESS, 0, KIND_SLEEP, 0, 0, 0);
      send_cmd(OP_TERMINATE, 0, KIND_IDLE, 0, 0, 0);
      send_cmd(OP_SET, 0, KIND_SLEEP, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 0);
      send_cmd(OP_SET, 15, KIND_TIMEOUT, 10, 32'hFFFF_FFFC, 0);
      send_cmd(OP_SET, 7, KIND_IDLE, 10, 32'h5555_AAAA, 0);
      send_cmd(OP_SET, 3, KIND_OTHER, 10, 32'hAAAA_5555, 0);
      send_cmd(OP_SET, 9, KIND_SLEEP, 20, 100, 0);
      send_cmd(OP_SET, 15, KIND_TIMEOUT, 10, 32'hFFFF_FFFE, 0);  // rearm
      send_cmd(OP_NONE, 4, KIND_SLEEP, 5, 5, 0);
      send_cmd(OP_PROCESS, 0, KIND_SLEEP, 6, 0, 0);  // wraps past issue time
      send_cmd(OP_PROCESS, 0, KIND_OTHER, 10, 0, 0);
      send_cmd(OP_PROCESS, 0, KIND_TIMEOUT, 32'hFFFF_FFFF, 0, 0);
      send_cmd(OP_SET, 1, KIND_IDLE, 5, 0, 0);
      send_cmd(OP_SET, 2, KIND_IDLE, 5, 0, 0);
      send_cmd(OP_SET, 2, KIND_IDLE, 0, 0, 0);       // disarm
      send_cmd(OP_SET, 6, KIND_IDLE, 8, 0, 0);
      send_cmd(OP_PROCESS, 0, KIND_IDLE, 4, 0, 0);
      send_cmd(OP_TERMINATE, 0, KIND_OTHER, 0, 0, 0);
      for (int i = 0; i < NUM_TIMERS; i++)
         send_cmd(OP_SET, i[3:0], KIND_IDLE, 7, 0, 0);
      send_cmd(OP_PROCESS, 0, KIND_IDLE, 7, 0, 0);   // full table fires

      // Random: bursts of sets then a process, terminate or no-op command.
      while (n_cmds < 215) begin
         gaps = (n_cmds < 180);
         repeat ($urandom_range(1, 6)) begin
            clock_now += $urandom_range(0, 40);
            send_cmd(OP_SET, 4'($urandom), kind_type'($urandom_range(0, 3)),
                     rand_dur(), ($urandom_range(0, 7) == 0) ? $urandom : clock_now,
                     gaps);
         end
         clock_now += $urandom_range(0, 60);
         case ($urandom_range(0, 9))
            0:       send_cmd(OP_TERMINATE, 4'($urandom),
                              kind_type'($urandom_range(0, 3)),
                              $urandom, $urandom, gaps);
            1:       send_cmd(OP_NONE, 4'($urandom),
                              kind_type'($urandom_range(0, 3)),
                              $urandom, $urandom, gaps);
            2:       send_cmd(OP_PROCESS, 4'($urandom),
                              kind_type'($urandom_range(0, 3)),
                              $urandom, $urandom, gaps);
            default: send_cmd(OP_PROCESS, 4'($urandom),
                              kind_type'($urandom_range(0, 3)),
                              ($urandom_range(0, 1)) ? clock_now
                                                     : $urandom_range(0, 70),
                              $urandom, gaps);
         endcase
      end

      // Drain, then allow the scan latency to settle.
      while (pending != 0 || busy) @(posedge clock);
      repeat (20 * (NUM_TIMERS + 2)) @(posedge clock);
      $display("Covered %0d commands and %0d result beats.", n_cmds, wake_beats);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
